// ===== rtl/q15_fir_filter_defines.svh =====
// Assertion macros for the checker file of the Q15 FIR filter.
`ifndef Q15_FIR_FILTER_DEFINES_SVH
`define Q15_FIR_FILTER_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted.
`define QFIR_ASSERT_RST(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define QFIR_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== rtl/qfir_pkg.sv =====
// Types and constants shared by the Q15 FIR filter modules.
`default_nettype none
package qfir_pkg;

  localparam int MAX_TAPS_DEF = 64;
  localparam int TAP_COUNT_W  = 7;
  localparam int TAP_IDX_W    = 6;
  localparam int SMP_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int RND          = 1 << 14;
  localparam int SHR          = 15;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_COUNT    = 2'd0,
    CFG_IQ_INPUT     = 2'd1,
    CFG_COMPLEX_TAPS = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic                    mode;
    logic [TAP_IDX_W-1:0]    tap_index;
    logic signed [SMP_W-1:0] tap_real;
    logic signed [SMP_W-1:0] tap_imag;
    logic signed [SMP_W-1:0] sample_i;
    logic signed [SMP_W-1:0] sample_q;
  } in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] out_i;
    logic signed [SMP_W-1:0] out_q;
  } out_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic                    store;
    logic [TAP_IDX_W-1:0]    tap_index;
    logic signed [SMP_W-1:0] tap_real;
    logic signed [SMP_W-1:0] tap_imag;
    logic signed [SMP_W-1:0] sample_i;
    logic signed [SMP_W-1:0] sample_q;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/qfir_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
`default_nettype none
module qfir_front
  import qfir_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  output logic      full,
  input  wire in_t  in_data,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  wire logic cmd_pop
);

  cmd_t       q_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;
  cmd_t       cmd_in;

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && cmd_valid;

  always_comb begin
    cmd_in.kind      = (in_data.mode == MODE_LOAD) ? CMD_LOAD : CMD_SAMPLE;
    cmd_in.store     = (32'(in_data.tap_index) < 32'(MAX_TAPS));
    cmd_in.tap_index = in_data.tap_index;
    cmd_in.tap_real  = in_data.tap_real;
    cmd_in.tap_imag  = in_data.tap_imag;
    cmd_in.sample_i  = in_data.sample_i;
    cmd_in.sample_q  = in_data.sample_q;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_r <= ~wr_r;
      end
      if (rd_en) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qfir_resq.sv =====
// Result queue: holds finished results until the consumer pops them.
`default_nettype none
module qfir_resq
  import qfir_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_push,
  input  wire out_t res,
  output logic      res_full,
  output logic      empty,
  input  wire logic pop,
  output out_t      out_data
);

  out_t       q_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign res_full = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign out_data = q_r[rd_r];
  assign wr_en    = res_push && !res_full;
  assign rd_en    = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_r <= ~wr_r;
      end
      if (rd_en) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qfir_back.sv =====
// Back end: tap and delay-line memories with a shared multiply-accumulate.
`default_nettype none
module qfir_back
  import qfir_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cmd_valid,
  input  wire cmd_t                   cmd,
  output logic                        cmd_pop,
  input  wire logic                   res_full,
  output logic                        res_push,
  output out_t                        res,
  input  wire logic [TAP_COUNT_W-1:0] tap_count,
  input  wire logic                   iq_input,
  input  wire logic                   complex_taps
);

  localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW   = $clog2(MAX_TAPS + 1);
  localparam int ACCW = 36 + AW;
  localparam logic [AW-1:0] LAST     = AW'(MAX_TAPS - 1);
  localparam logic [CW-1:0] FILL_MAX = CW'(MAX_TAPS);
  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(32'sd1073741823);
  localparam logic signed [ACCW-1:0] SAT_LO = ACCW'(-32'sd1073741824);
  localparam logic signed [ACCW-1:0] ACC_INIT = ACCW'(RND);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  logic signed [SMP_W-1:0] coef_re_mem [MAX_TAPS];
  logic signed [SMP_W-1:0] coef_im_mem [MAX_TAPS];
  logic signed [SMP_W-1:0] hist_i_mem  [MAX_TAPS];
  logic signed [SMP_W-1:0] hist_q_mem  [MAX_TAPS];

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          wp_r, wp_nxt;
  logic [CW-1:0]          fill_r, fill_nxt;
  logic [AW-1:0]          h_r, h_nxt;
  logic [AW-1:0]          k_r, k_nxt;
  logic [AW-1:0]          last_k_r, last_k_nxt;
  logic signed [ACCW-1:0] acc_i_r, acc_i_nxt;
  logic signed [ACCW-1:0] acc_q_r, acc_q_nxt;

  logic                    v1_r, v2_r;
  logic signed [SMP_W-1:0] cr_r, ci_r, xi_r, xq_r;
  logic signed [31:0]      pri_r, prq_r, piq_r, pii_r;
  logic signed [32:0]      term_i, term_q;

  logic          is_sample, start, coef_we, hist_we, rd_en;
  logic [31:0]   tap_addr32, tc32, nc32, fill32, ne32;
  logic [CW-1:0] fill_inc;
  logic [AW-1:0] wp_wrap;
  logic signed [SMP_W-1:0] hist_q_in;

  function automatic logic signed [SMP_W-1:0] finish(input logic signed [ACCW-1:0] a);
    logic signed [ACCW-1:0] s;
    s = a;
    if (a > SAT_HI) begin
      s = SAT_HI;
    end else if (a < SAT_LO) begin
      s = SAT_LO;
    end
    return s[SHR+SMP_W-1:SHR];
  endfunction

  assign is_sample  = (cmd.kind == CMD_SAMPLE);
  assign tap_addr32 = 32'(cmd.tap_index);
  assign fill_inc   = (fill_r == FILL_MAX) ? fill_r : fill_r + 1'b1;
  assign wp_wrap    = (wp_r == LAST) ? '0 : wp_r + 1'b1;
  assign tc32       = 32'(tap_count);
  assign nc32       = (tc32 == 32'd0) ? 32'd1 :
                      (tc32 > 32'(MAX_TAPS)) ? 32'(MAX_TAPS) : tc32;
  assign fill32     = 32'(fill_inc);
  assign ne32       = (nc32 < fill32) ? nc32 : fill32;
  assign hist_q_in  = iq_input ? cmd.sample_q : '0;

  assign start   = (state_r == ST_IDLE) && cmd_valid && is_sample && !res_full;
  assign coef_we = (state_r == ST_IDLE) && cmd_valid && !is_sample && cmd.store;
  assign hist_we = start;
  assign rd_en   = (state_r == ST_RUN);
  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid && (!is_sample || !res_full);

  always_comb begin
    if (iq_input && complex_taps) begin
      term_i = 33'(pri_r) - 33'(piq_r);
      term_q = 33'(prq_r) + 33'(pii_r);
    end else begin
      term_i = 33'(pri_r);
      term_q = 33'(prq_r);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    fill_nxt   = fill_r;
    h_nxt      = h_r;
    k_nxt      = k_r;
    last_k_nxt = last_k_r;
    acc_i_nxt  = acc_i_r;
    acc_q_nxt  = acc_q_r;
    res_push   = 1'b0;
    res.out_i  = finish(acc_i_r);
    res.out_q  = iq_input ? finish(acc_q_r) : '0;
    if (v2_r) begin
      acc_i_nxt = acc_i_r + ACCW'(term_i);
      acc_q_nxt = acc_q_r + ACCW'(term_q);
    end
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && !is_sample) begin
          wp_nxt   = '0;
          fill_nxt = '0;
        end else if (start) begin
          h_nxt      = wp_r;
          wp_nxt     = wp_wrap;
          fill_nxt   = fill_inc;
          k_nxt      = '0;
          last_k_nxt = AW'(ne32 - 32'd1);
          acc_i_nxt  = ACC_INIT;
          acc_q_nxt  = ACC_INIT;
          state_nxt  = ST_RUN;
        end
      end
      ST_RUN: begin
        k_nxt = k_r + 1'b1;
        h_nxt = (h_r == '0) ? LAST : h_r - 1'b1;
        if (k_r == last_k_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_re_mem[tap_addr32[AW-1:0]] <= cmd.tap_real;
      coef_im_mem[tap_addr32[AW-1:0]] <= cmd.tap_imag;
    end
    if (rd_en) begin
      cr_r <= coef_re_mem[k_r];
      ci_r <= coef_im_mem[k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_i_mem[wp_r] <= cmd.sample_i;
      hist_q_mem[wp_r] <= hist_q_in;
    end
    if (rd_en) begin
      xi_r <= hist_i_mem[h_r];
      xq_r <= hist_q_mem[h_r];
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      pri_r <= cr_r * xi_r;
      prq_r <= cr_r * xq_r;
      piq_r <= ci_r * xq_r;
      pii_r <= ci_r * xi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      v1_r    <= rd_en;
      v2_r    <= v1_r;
    end
    h_r      <= h_nxt;
    k_r      <= k_nxt;
    last_k_r <= last_k_nxt;
    acc_i_r  <= acc_i_nxt;
    acc_q_r  <= acc_q_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/q15_fir_filter.sv =====
// Top level of the Q15 FIR filter: config registers, front end, MAC back end, result queue.
//
// Input beats enter through push/full, like writing a queue: a beat is taken
// when push is high and full is low. mode 0 loads one tap and clears the
// delay lines; mode 1 pushes a sample and yields one result. Results leave
// through empty/pop: the oldest result sits on out_data while empty is low
// and is taken when pop is high. The cfg port (cfg_valid/cfg_ready, always
// ready) writes tap_count, iq_input and complex_taps; write only while idle.
// A two-entry command queue sits between the front end and the MAC engine.
// The engine takes a new command only when idle. A sample runs over n taps,
// n = min(tap_count clamped to 1..MAX_TAPS, samples since the last clear),
// with the single multiply-accumulate unit stepping one tap per cycle
// through the read, multiply and accumulate stages; the engine then drains
// those stages and pushes the result into the result queue.
// While the consumer stalls, up to two results wait in the result queue and
// two more beats wait in the command queue; then full goes high.
// Reset empties both queues, zeroes the delay lines (through a fill count)
// and sets tap_count to 1 with real samples and real taps. Taps are
// undefined until loaded.
`default_nettype none
module q15_fir_filter
  import qfir_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  output logic                        full,
  input  wire in_t                    in_data,
  output logic                        empty,
  input  wire logic                   pop,
  output out_t                        out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [TAP_COUNT_W-1:0] cfg_data
);

  logic [TAP_COUNT_W-1:0] tap_count_r;
  logic                   iq_input_r;
  logic                   complex_taps_r;

  logic cmd_valid, cmd_pop, res_full, res_push;
  cmd_t cmd;
  out_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r    <= TAP_COUNT_W'(1);
      iq_input_r     <= 1'b0;
      complex_taps_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TAP_COUNT:    tap_count_r    <= cfg_data;
        CFG_IQ_INPUT:     iq_input_r     <= cfg_data[0];
        CFG_COMPLEX_TAPS: complex_taps_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  qfir_front #(
    .MAX_TAPS(MAX_TAPS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  qfir_back #(
    .MAX_TAPS(MAX_TAPS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res),
    .tap_count   (tap_count_r),
    .iq_input    (iq_input_r),
    .complex_taps(complex_taps_r)
  );

  qfir_resq u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_push(res_push),
    .res     (res),
    .res_full(res_full),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/qfir_chk.sv =====
// Port-level checker for the Q15 FIR filter and its bind to the top level.
`default_nettype none
`include "q15_fir_filter_defines.svh"
module qfir_chk
  import qfir_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic push,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire out_t out_data
);

  `QFIR_ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> empty && !full, "queues not clear after reset")
  `QFIR_ASSERT_RST(a_full_needs_push, clk, rst_n, !full && !push |=> !full, "full rose without a beat")
  `QFIR_ASSERT_RST(a_empty_needs_pop, clk, rst_n, !empty && !pop |=> !empty, "result lost")
  `QFIR_ASSERT_RST(a_out_hold, clk, rst_n, !empty && !pop |=> $stable(out_data), "result changed")

endmodule

bind q15_fir_filter qfir_chk u_chk (
  .clk     (clk),
  .rst_n   (rst_n),
  .push    (push),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .out_data(out_data)
);
`default_nettype wire

// ===== tb/tb_q15_fir_filter.sv =====
// Self-checking testbench of the Q15 FIR filter: directed table, then random phases per config.
`timescale 1ns / 100ps
module tb_q15_fir_filter;
  import qfir_pkg::*;

  localparam int TAPS     = MAX_TAPS_DEF;
  localparam int DRAIN    = 3 * (TAPS + 5) + 40;
  localparam int WATCHDOG = 5000;
  localparam int PHASES   = 9;
  localparam int PER_PHASE = 150;

  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    cfg_idx_t              reg_idx;
    logic [TAP_COUNT_W-1:0] reg_val;
    in_t                   beat;
    bit                    typed;
    out_t                  want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   push = 1'b0;
  logic                   full;
  in_t                    in_data = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  out_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [TAP_COUNT_W-1:0] cfg_data = '0;

  q15_fir_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // filter state mirrored in the testbench
  logic signed [SMP_W-1:0] coef_re_m [TAPS];
  logic signed [SMP_W-1:0] coef_im_m [TAPS];
  logic signed [SMP_W-1:0] hist_i_m [TAPS];
  logic signed [SMP_W-1:0] hist_q_m [TAPS];
  logic [TAP_IDX_W-1:0]    wpos_m = '0;
  logic [TAP_COUNT_W-1:0]  taps_cfg = 7'd1;
  logic                    iq_cfg = 1'b0;
  logic                    cplx_cfg = 1'b0;

  out_t pending_out[$];
  int   err_count = 0;
  int   send_idle = 35;
  int   recv_idle = 88;
  int   quiet = 0;

  function automatic logic signed [SMP_W-1:0] q15_sat_shift(longint acc);
    longint lo = -(longint'(1) << 30);
    longint hi = (longint'(1) << 30) - 1;
    if (acc < lo) acc = lo;
    if (acc > hi) acc = hi;
    return 16'(acc >>> SHR);
  endfunction

  function automatic void clear_delay_lines();
    foreach (hist_i_m[k]) begin
      hist_i_m[k] = '0;
      hist_q_m[k] = '0;
    end
    wpos_m = '0;
  endfunction

  function automatic bit fir_predict(input in_t b, output out_t r);
    int                   n;
    logic [TAP_IDX_W-1:0] p;
    logic [TAP_IDX_W-1:0] h;
    longint               acc_i;
    longint               acc_q;
    int                   cr, ci, xi, xq;
    bit                   cplx;
    r = '0;
    if (b.mode == MODE_LOAD) begin
      coef_re_m[b.tap_index] = b.tap_real;
      coef_im_m[b.tap_index] = b.tap_imag;
      clear_delay_lines();
      return 1'b0;
    end
    cplx = iq_cfg && cplx_cfg;
    n = taps_cfg;
    if (n < 1) n = 1;
    if (n > TAPS) n = TAPS;
    p = wpos_m;
    hist_i_m[p] = b.sample_i;
    hist_q_m[p] = iq_cfg ? b.sample_q : '0;
    wpos_m = p + 1'b1;
    acc_i = RND;
    acc_q = RND;
    for (int k = 0; k < n; k++) begin
      h = p - TAP_IDX_W'(k);
      cr = coef_re_m[k];
      ci = coef_im_m[k];
      xi = hist_i_m[h];
      xq = hist_q_m[h];
      if (cplx) begin
        acc_i += longint'(cr) * xi - longint'(ci) * xq;
        acc_q += longint'(cr) * xq + longint'(ci) * xi;
      end else begin
        acc_i += longint'(cr) * xi;
        acc_q += longint'(cr) * xq;
      end
    end
    r.out_i = q15_sat_shift(acc_i);
    r.out_q = iq_cfg ? q15_sat_shift(acc_q) : '0;
    return 1'b1;
  endfunction

  function automatic row_t r_cfg(cfg_idx_t idx, int val);
    row_t r;
    r = '{kind: ROW_BEAT, reg_idx: CFG_TAP_COUNT, default: '0};
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val[TAP_COUNT_W-1:0];
    return r;
  endfunction

  function automatic row_t r_load(int idx, int re, int im);
    row_t r;
    r = '{kind: ROW_BEAT, reg_idx: CFG_TAP_COUNT, default: '0};
    r.kind = ROW_BEAT;
    r.beat.mode = MODE_LOAD;
    r.beat.tap_index = idx[TAP_IDX_W-1:0];
    r.beat.tap_real = re[SMP_W-1:0];
    r.beat.tap_imag = im[SMP_W-1:0];
    return r;
  endfunction

  function automatic row_t r_smp(int si, int sq, bit typed = 1'b0, int oi = 0, int oq = 0);
    row_t r;
    r = '{kind: ROW_BEAT, reg_idx: CFG_TAP_COUNT, default: '0};
    r.kind = ROW_BEAT;
    r.beat.mode = MODE_SAMPLE;
    r.beat.sample_i = si[SMP_W-1:0];
    r.beat.sample_q = sq[SMP_W-1:0];
    r.typed = typed;
    r.want.out_i = oi[SMP_W-1:0];
    r.want.out_q = oq[SMP_W-1:0];
    return r;
  endfunction

  function automatic logic [SMP_W-1:0] rand_coef(int cls);
    int pick;
    pick = $urandom_range(4);
    case (cls)
      0: return SMP_W'($urandom);
      1: return SMP_W'(int'($urandom_range(2047)) - 1024);
      default: begin
        case (pick)
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return SMP_W'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 16'h7fff : 16'h8000;
    return SMP_W'($urandom);
  endfunction

  function automatic in_t rand_load(int idx, int cls);
    in_t b;
    b = '0;
    b.sample_i = SMP_W'($urandom);
    b.sample_q = SMP_W'($urandom);
    b.mode = MODE_LOAD;
    b.tap_index = idx[TAP_IDX_W-1:0];
    b.tap_real = rand_coef(cls);
    b.tap_imag = rand_coef(cls);
    return b;
  endfunction

  task automatic send_beat(in_t b, bit typed, out_t want);
    out_t r;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (full);
    if (fir_predict(b, r)) pending_out.push_back(typed ? want : r);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [TAP_COUNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TAP_COUNT:    taps_cfg = val;
      CFG_IQ_INPUT:     iq_cfg = val[0];
      CFG_COMPLEX_TAPS: cplx_cfg = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_out.size() == 0) begin
          $error("unexpected result beat: out_i %0d out_q %0d", out_data.out_i, out_data.out_q);
          err_count++;
        end else begin
          automatic out_t want = pending_out.pop_front();
          if (out_data.out_i !== want.out_i) begin
            $error("out_i: expected %0d, got %0d", want.out_i, out_data.out_i);
            err_count++;
          end
          if (out_data.out_q !== want.out_q) begin
            $error("out_q: expected %0d, got %0d", want.out_q, out_data.out_q);
            err_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet >= WATCHDOG) begin
        $display("tb_q15_fir_filter: done, errors");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    row_t plan[$];
    int   ph_taps [PHASES] = '{1, 64, 127, 0, 8, 3, 64, 17, 33};
    bit   ph_iq   [PHASES] = '{1, 1, 0, 1, 1, 0, 0, 1, 1};
    bit   ph_cplx [PHASES] = '{1, 1, 1, 0, 1, 0, 1, 1, 0};
    int   cls;
    in_t  b;
    out_t none;
    none = '0;
    foreach (coef_re_m[k]) begin
      coef_re_m[k] = '0;
      coef_im_m[k] = '0;
    end
    clear_delay_lines();

    // reset config: one tap, real samples, real taps
    plan.push_back(r_load(0, 32767, -32768));
    plan.push_back(r_smp(32767, -1, 1, 32766, 0));
    plan.push_back(r_smp(-32768, 32767, 1, -32767, 0));
    plan.push_back(r_load(0, -32768, 0));
    plan.push_back(r_smp(-32768, 0, 1, 32767, 0));
    plan.push_back(r_smp(0, 0, 1, 0, 0));
    plan.push_back(r_smp(32767, 0, 1, -32767, 0));
    plan.push_back(r_cfg(CFG_IQ_INPUT, 1));
    plan.push_back(r_smp(100, -32768, 1, -100, 32767));
    plan.push_back(r_cfg(CFG_COMPLEX_TAPS, 1));
    plan.push_back(r_load(0, 0, 32767));
    plan.push_back(r_smp(1000, 0, 1, 0, 1000));
    plan.push_back(r_smp(0, 1000, 1, -1000, 0));
    plan.push_back(r_cfg(CFG_IQ_INPUT, 0));
    plan.push_back(r_smp(1000, 5, 1, 0, 0));
    plan.push_back(r_load(1, 12345, -777));
    plan.push_back(r_load(2, -20000, 30000));
    plan.push_back(r_load(3, 32767, -32768));
    plan.push_back(r_load(63, -1, 1));
    plan.push_back(r_cfg(CFG_TAP_COUNT, 4));
    plan.push_back(r_cfg(CFG_IQ_INPUT, 1));
    plan.push_back(r_smp(20000, -15000));
    plan.push_back(r_smp(-32768, 32767));
    plan.push_back(r_smp(32767, 32767));
    plan.push_back(r_smp(-1, -32768));
    plan.push_back(r_cfg(CFG_TAP_COUNT, 0));
    plan.push_back(r_smp(-32768, 12345));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 3)
        0: begin send_idle = 35; recv_idle = 88; end
        1: begin send_idle = 88; recv_idle = 35; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      cls = ph % 3;
      wait_idle();
      write_reg(CFG_TAP_COUNT, TAP_COUNT_W'(ph_taps[ph]));
      write_reg(CFG_IQ_INPUT, TAP_COUNT_W'(ph_iq[ph]));
      write_reg(CFG_COMPLEX_TAPS, TAP_COUNT_W'(ph_cplx[ph]));
      for (int t = 0; t < TAPS; t++) send_beat(rand_load(t, cls), 1'b0, none);
      for (int n = 0; n < PER_PHASE; n++) begin
        if ($urandom_range(99) < 4) begin
          b = rand_load($urandom_range(TAPS - 1), cls);
        end else begin
          b = '0;
          b.tap_real = SMP_W'($urandom);
          b.mode = MODE_SAMPLE;
          b.sample_i = rand_sample();
          b.sample_q = rand_sample();
        end
        send_beat(b, 1'b0, none);
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("tb_q15_fir_filter: done, clean");
    end else begin
      $display("tb_q15_fir_filter: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/qfir_pkg.sv
rtl/qfir_front.sv
rtl/qfir_resq.sv
rtl/qfir_back.sv
rtl/q15_fir_filter.sv
rtl/qfir_chk.sv
tb/tb_q15_fir_filter.sv
